// ===== rtl/antialiased_line_rasterizer_macros.svh =====
// Assertion helpers shared by the rasterizer modules.
// Each expects clk_i and rst_ni in scope.
`ifndef ANTIALIASED_LINE_RASTERIZER_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AALR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AALR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aalr_pkg.sv =====
`timescale 1ns / 1ps
package aalr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int WALK_W     = COORD_BITS + 1;
  localparam int ACC_W      = 8 + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(ACC_W + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // 255.0 and 127.5 in unsigned Q8.FRAC_BITS
  localparam logic [ACC_W-1:0] FULL_SCALE = {8'd255, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W-1:0] HALF_SCALE = FULL_SCALE >> 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
  } oct_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] finish_x;
    logic [COORD_BITS-1:0] finish_y;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [7:0]            level;
    logic                  last;
  } out_t;

  // Classified item as queued between front and back
  typedef struct packed {
    logic              op;
    oct_e              octant;
    logic [WALK_W-1:0] walk_x;
    logic [WALK_W-1:0] walk_y;
    logic [WALK_W-1:0] stop_x;
    logic [WALK_W-1:0] fdx;
    logic [WALK_W-1:0] fdy;
  } seg_t;

  function automatic logic [WALK_W-1:0] neg_w(input logic [WALK_W-1:0] v);
    return WALK_W'(0) - v;
  endfunction

endpackage

// ===== rtl/aalr_front.sv =====
`timescale 1ns / 1ps
module aalr_front (
  input  aalr_pkg::in_t  item_i,
  output aalr_pkg::seg_t seg_o
);
  import aalr_pkg::*;

  function automatic oct_e classify(input logic signed [WALK_W-1:0] dx,
                                    input logic signed [WALK_W-1:0] dy);
    logic signed [WALK_W-1:0] ax;
    logic signed [WALK_W-1:0] ay;
    oct_e o;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dx == 0 && dy == 0) begin
      o = OCT_0;
    end else if (dx > 0 && dy >= 0) begin
      o = (dx >= dy) ? OCT_0 : OCT_1;
    end else if (dx == 0 && dy > 0) begin
      o = OCT_1;
    end else if (dx < 0 && dy > 0) begin
      o = (ax <= dy) ? OCT_2 : OCT_3;
    end else if (dx < 0 && dy <= 0) begin
      o = (ax >= ay) ? OCT_4 : OCT_5;
    end else begin
      o = (dx < ay) ? OCT_6 : OCT_7;
    end
    return o;
  endfunction

  // Map a point into octant 0; result is {x, y}
  function automatic logic [2*WALK_W-1:0] fold(input oct_e o,
                                               input logic [WALK_W-1:0] x,
                                               input logic [WALK_W-1:0] y);
    logic [WALK_W-1:0] a;
    logic [WALK_W-1:0] b;
    a = x;
    b = y;
    case (o)
      OCT_1:   begin a = y;        b = x;        end
      OCT_2:   begin a = y;        b = neg_w(x); end
      OCT_3:   begin a = neg_w(x); b = y;        end
      OCT_4:   begin a = neg_w(x); b = neg_w(y); end
      OCT_5:   begin a = neg_w(y); b = neg_w(x); end
      OCT_6:   begin a = neg_w(y); b = x;        end
      OCT_7:   begin a = x;        b = neg_w(y); end
      default: begin a = x;        b = y;        end
    endcase
    return {a, b};
  endfunction

  logic [WALK_W-1:0] sx, sy, ex, ey;
  logic signed [WALK_W-1:0] dx, dy;
  oct_e              oct;
  logic [WALK_W-1:0] fx0, fy0, fx1, fy1;

  always_comb begin
    sx  = {1'b0, item_i.start_x};
    sy  = {1'b0, item_i.start_y};
    ex  = {1'b0, item_i.finish_x};
    ey  = {1'b0, item_i.finish_y};
    dx  = $signed(ex - sx);
    dy  = $signed(ey - sy);
    oct = classify(dx, dy);
    {fx0, fy0} = fold(oct, sx, sy);
    {fx1, fy1} = fold(oct, ex, ey);

    seg_o.op     = item_i.op;
    seg_o.octant = oct;
    seg_o.walk_x = fx0;
    seg_o.walk_y = fy0;
    seg_o.stop_x = fx1;
    seg_o.fdx    = fx1 - fx0;
    seg_o.fdy    = fy1 - fy0;
  end

endmodule

// ===== rtl/aalr_fifo.sv =====
`timescale 1ns / 1ps
module aalr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aalr_pkg::seg_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output aalr_pkg::seg_t pop_data_o
);
  import aalr_pkg::*;

  seg_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? bump(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `include "antialiased_line_rasterizer_macros.svh"

  `AALR_ASSERT_NOW(a_no_overflow, push_i && !pop_i, cnt_q != QCNT_W'(QDEPTH), "queue overflow")
  `AALR_ASSERT_NOW(a_no_underflow, pop_i, cnt_q != '0, "queue underflow")

endmodule

// ===== rtl/aalr_div.sv =====
`timescale 1ns / 1ps
module aalr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [aalr_pkg::WALK_W-1:0]   fdx_i,
  input  logic [aalr_pkg::WALK_W-1:0]   fdy_i,
  output logic                          done_o,
  output logic [aalr_pkg::ACC_W-1:0]    quot_o
);
  import aalr_pkg::*;

  localparam int NUM_W = ACC_W + WALK_W;

  logic                 run_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [WALK_W-1:0]    rem_q, den_q;
  logic [ACC_W-1:0]     quo_q;

  logic [8+WALK_W-1:0]  prod;
  logic [NUM_W-1:0]     num;
  logic [WALK_W:0]      rem_sh, diff;
  logic                 ge;

  always_comb begin
    // 255 * fdy, then scale by 2^FRAC_BITS
    prod   = {fdy_i, 8'd0} - {8'd0, fdy_i};
    num    = {prod, {FRAC_BITS{1'b0}}};
    rem_sh = {rem_q, quo_q[ACC_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(ACC_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle; the low part of the dividend shifts out
  // as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= fdx_i;
      rem_q <= num[NUM_W-1 -: WALK_W];
      quo_q <= num[ACC_W-1:0];
    end else if (run_q) begin
      rem_q <= ge ? diff[WALK_W-1:0] : rem_sh[WALK_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

  // Zero-length segment: slope is zero
  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? '0 : quo_q;

  `include "antialiased_line_rasterizer_macros.svh"

  `AALR_ASSERT_NOW(a_quot_range, done_q, quot_o <= FULL_SCALE, "slope above full scale")
  `AALR_ASSERT_NOW(a_start_idle, start_i, !run_q, "divider restarted while running")

endmodule

// ===== rtl/aalr_back.sv =====
`timescale 1ns / 1ps
module aalr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  aalr_pkg::seg_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output aalr_pkg::out_t out_data_o
);
  import aalr_pkg::*;

  back_state_e state_q, state_d;

  oct_e              octant_q;
  logic [WALK_W-1:0] walk_x_q, walk_y_q, stop_x_q;
  logic [ACC_W-1:0]  err_q, slope_q, step_q;

  logic              out_valid_q;
  out_t              out_q;

  logic              div_start, div_done;
  logic [ACC_W-1:0]  div_quot;

  logic              out_free, emit, fin;
  logic [WALK_W-1:0] ux, uy;
  logic [ACC_W-1:0]  shade;
  out_t              pix;

  aalr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .fdx_i  (q_data_i.fdx),
    .fdy_i  (q_data_i.fdy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state_q)
      BK_IDLE: begin
        // drop ticks while idle
        q_pop_o   = q_valid_i;
        div_start = q_valid_i && (q_data_i.op == OP_LOAD);
      end
      BK_RUN: begin
        if (q_valid_i && q_data_i.op == OP_LOAD) begin
          q_pop_o   = 1'b1;
          div_start = 1'b1;
        end else if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          emit    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (div_start) state_d = BK_DIV;
      BK_DIV:  if (div_done) state_d = BK_RUN;
      BK_RUN: begin
        if (div_start) begin
          state_d = BK_DIV;
        end else if (emit && fin) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Pixel for the current walk position
  always_comb begin
    fin = (walk_x_q == stop_x_q);
    ux  = walk_x_q;
    uy  = walk_y_q;
    case (octant_q)
      OCT_1:   begin ux = walk_y_q;        uy = walk_x_q;        end
      OCT_2:   begin ux = neg_w(walk_y_q); uy = walk_x_q;        end
      OCT_3:   begin ux = neg_w(walk_x_q); uy = walk_y_q;        end
      OCT_4:   begin ux = neg_w(walk_x_q); uy = neg_w(walk_y_q); end
      OCT_5:   begin ux = neg_w(walk_y_q); uy = neg_w(walk_x_q); end
      OCT_6:   begin ux = walk_y_q;        uy = neg_w(walk_x_q); end
      OCT_7:   begin ux = walk_x_q;        uy = neg_w(walk_y_q); end
      default: begin ux = walk_x_q;        uy = walk_y_q;        end
    endcase
    shade     = octant_q[0] ? (FULL_SCALE - err_q) : err_q;
    pix.pix_x = ux[COORD_BITS-1:0];
    pix.pix_y = uy[COORD_BITS-1:0];
    pix.level = shade[ACC_W-1:FRAC_BITS];
    pix.last  = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= pix;
    end
    if (div_start) begin
      octant_q <= q_data_i.octant;
      walk_x_q <= q_data_i.walk_x;
      walk_y_q <= q_data_i.walk_y;
      stop_x_q <= q_data_i.stop_x;
    end else if (state_q == BK_DIV && div_done) begin
      slope_q <= div_quot;
      step_q  <= FULL_SCALE - div_quot;
      err_q   <= HALF_SCALE;
    end else if (emit) begin
      // advance one pixel along the major axis
      if (err_q < step_q) begin
        err_q <= err_q + slope_q;
      end else begin
        walk_y_q <= walk_y_q + WALK_W'(1);
        err_q    <= err_q - step_q;
      end
      walk_x_q <= walk_x_q + WALK_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "antialiased_line_rasterizer_macros.svh"

  `AALR_ASSERT_NOW(a_no_pop_in_div, state_q == BK_DIV, !q_pop_o, "queue popped during division")
  `AALR_ASSERT_NOW(a_err_range, state_q == BK_RUN, err_q < FULL_SCALE, "error term out of range")
  `AALR_ASSERT_NEXT(a_last_ends, emit && fin && !div_start, state_q == BK_IDLE, "walk past last pixel")

endmodule

// ===== rtl/antialiased_line_rasterizer.sv =====
`timescale 1ns / 1ps
// Anti-aliased line rasterizer.
// Input channel (in_valid_i / in_ready_o / in_data_i): op = load carries the two
// endpoints of a segment; op = tick asks for the next pixel of the running segment.
// Output channel (out_valid_o / out_ready_i / out_data_o): one pixel per productive
// tick with its coordinates, 8-bit intensity and a flag on the final pixel.
// A front stage classifies the octant and folds the endpoints on the way into a
// two-entry queue; the back stage runs the walk and owns a registered output.
// Throughput: ticks stream at one pixel per cycle while the receiver keeps up. A load
// holds the back stage while the bit-serial slope divider runs (one quotient bit per
// cycle); ticks that follow a load wait in the queue until the slope is ready.
// Latency: a tick's pixel is shown in the cycle after the back stage takes it.
// A tick while no segment runs is dropped; a load mid-segment abandons it.
// When the receiver stalls, the output register holds its pixel, the back stage stops
// taking ticks, and the queue fills until in_ready_o drops.
// Reset clears the queue and returns the walker to idle with no pixel pending.
module antialiased_line_rasterizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aalr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output aalr_pkg::out_t out_data_o
);
  import aalr_pkg::*;

  seg_t seg_in, seg_head;
  logic q_full, q_valid, q_pop, q_push;

  // Classify and fold on the way into the queue
  aalr_front u_front (
    .item_i(in_data_i),
    .seg_o (seg_in)
  );

  // Accept whenever the queue has room
  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && in_ready_o;

  aalr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(seg_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (seg_head)
  );

  // Walk, divide and hold the result for transfer
  aalr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (seg_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
